>>> design/lzss_ring_decompressor_defines.svh
// Assertion macros shared by the LZSS ring decompressor RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef LZSS_RING_DECOMPRESSOR_DEFINES_SVH
`define LZSS_RING_DECOMPRESSOR_DEFINES_SVH

// Antecedent holds in this cycle, consequent holds in the same cycle.
`define LZSD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Antecedent holds in this cycle, consequent holds in the next cycle.
`define LZSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> design/lzsd_pkg.sv
// Package for the LZSS ring decompressor: ring geometry, pointer types
// and the status struct passed from the ring unit. No dependencies.
`default_nettype none

package lzsd_pkg;

    localparam int RING_DEPTH = 4096;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int MAX_MATCH  = 18;
    localparam int MATCH_BIAS = 2;
    localparam int RUN_W      = $clog2(MAX_MATCH + 1);

    typedef logic [RING_AW-1:0] t_ring_addr;
    typedef logic [RING_AW:0]   t_ring_cnt;
    typedef logic [RUN_W-1:0]   t_run_len;
    typedef logic [15:0]        t_flags;

    // Upper half of a freshly loaded flag word marks eight tokens pending
    localparam logic [7:0] FLAG_MARK = 8'hFF;

    typedef struct packed {
        t_ring_addr wp;
        t_ring_cnt  cnt;
    } t_ring_ptr;

    typedef struct packed {
        logic      hit;
        t_ring_ptr nxt;
    } t_ring_step;

    localparam t_ring_addr START_PTR      = t_ring_addr'(RING_DEPTH - MAX_MATCH);
    localparam t_ring_ptr  RING_PTR_RESET = '{wp: START_PTR, cnt: '0};

endpackage

`default_nettype wire

>>> design/lzsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lzsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/lzsd_ring_unit.sv
// Ring bookkeeping unit: written-entry check for a read address and
// the advanced write pointer and fill count. Depends on lzsd_pkg.
`default_nettype none

module lzsd_ring_unit (
    input  wire lzsd_pkg::t_ring_ptr  i_ptr,
    input  wire lzsd_pkg::t_ring_addr i_src,
    output lzsd_pkg::t_ring_step      o_step
);

    import lzsd_pkg::*;

    t_ring_addr back;

    // Distance behind the write pointer, modulo the ring size
    assign back = i_ptr.wp - t_ring_addr'(1) - i_src;

    // Entry is live when it lies within the entries written this stream
    assign o_step.hit = ({1'b0, back} < i_ptr.cnt);

    // Advance pointer, saturate the count at the ring size
    assign o_step.nxt.wp  = i_ptr.wp + t_ring_addr'(1);
    assign o_step.nxt.cnt = (i_ptr.cnt == t_ring_cnt'(RING_DEPTH)) ?
                            i_ptr.cnt : i_ptr.cnt + t_ring_cnt'(1);

endmodule

`default_nettype wire

>>> design/lzss_ring_decompressor.sv
// Top level of the LZSS ring decompressor: token sequencer, output register.
// Depends on lzsd_pkg, lzsd_ring_unit, lzsd_ram and the assertion header.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | sink      | i_in_valid / o_in_stall    | i_in_byte, i_last_in
//  out     | source    | o_out_valid / i_out_stall  | o_out_byte, o_last_of_run
//  cfg     | sink      | i_cfg_valid / o_cfg_ready  | i_cfg_data (fill byte)
//
// Flag byte and first match byte are taken in S_IDLE; a literal then passes through S_LIT.
// Match: 3 to 18 decoded bytes, each read from the ring in S_MRD, then written back and emitted
// in S_MWR, since the ring's read data is registered.
// Synchronous active-low reset; the ring is never cleared, a fill count
// marks which entries belong to the current stream.
// Output stall holds the sequencer before it emits; the output register lets
// a new request enter while the last result still waits.
`default_nettype none

module lzss_ring_decompressor (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_last_in,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic      [7:0] o_out_byte,
    output logic            o_last_of_run,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);

    import lzsd_pkg::*;

    `include "lzss_ring_decompressor_defines.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_LIT,
        S_MRD,
        S_MWR
    } t_state;

    t_state     r_state, n_state;
    t_ring_ptr  r_ptr, n_ptr;
    t_flags     r_flags, n_flags;
    logic       r_pair, n_pair;
    logic [7:0] r_pend, n_pend;
    logic [7:0] r_fill, n_fill;
    logic [7:0] r_byte, n_byte;
    t_ring_addr r_src, n_src;
    t_run_len   r_left, n_left;
    logic       r_last, n_last;
    logic       r_hit, n_hit;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_last, n_out_last;

    t_ring_step step;
    logic [7:0] ram_q;
    logic [7:0] emit_byte;
    logic       ram_we;
    logic       in_acc;
    logic       out_free;
    logic       finish;

    // Shared ring bookkeeping
    lzsd_ring_unit u_ring (
        .i_ptr  (r_ptr),
        .i_src  (r_src),
        .o_step (step)
    );

    // History ring
    lzsd_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ptr.wp),
        .i_wdata (emit_byte),
        .i_re    (r_state == S_MRD),
        .i_raddr (r_src),
        .o_rdata (ram_q)
    );

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // Byte to emit and append: literal, live ring entry or fill byte
    always_comb begin
        emit_byte = r_byte;
        if (r_state == S_MWR) begin
            emit_byte = r_hit ? ram_q : r_fill;
        end
    end

    assign ram_we = ((r_state == S_LIT) || (r_state == S_MWR)) && out_free;

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_flags     = r_flags;
        n_pair      = r_pair;
        n_pend      = r_pend;
        n_fill      = r_fill;
        n_byte      = r_byte;
        n_src       = r_src;
        n_left      = r_left;
        n_last      = r_last;
        n_hit       = r_hit;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        finish      = 1'b0;

        // Drop the output once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // Take the fill byte
        if (i_cfg_valid && o_cfg_ready) begin
            n_fill = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_last = i_last_in;
                    if (r_pair) begin
                        // Second match byte: start the copy
                        n_src   = {i_in_byte[7:4], r_pend};
                        n_left  = t_run_len'(i_in_byte[3:0]) + t_run_len'(MATCH_BIAS + 1);
                        n_pair  = 1'b0;
                        n_flags = r_flags >> 1;
                        n_state = S_MRD;
                    end else if (!r_flags[8]) begin
                        // Flag byte
                        n_flags = {FLAG_MARK, i_in_byte};
                        finish  = 1'b1;
                    end else if (r_flags[0]) begin
                        // Literal
                        n_byte  = i_in_byte;
                        n_flags = r_flags >> 1;
                        n_state = S_LIT;
                    end else begin
                        // First match byte: hold low offset bits
                        n_pend = i_in_byte;
                        n_pair = 1'b1;
                        finish = 1'b1;
                    end
                end
            end
            S_LIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = emit_byte;
                    n_out_last  = 1'b1;
                    n_ptr       = step.nxt;
                    n_state     = S_IDLE;
                    finish      = 1'b1;
                end
            end
            S_MRD: begin
                n_hit   = step.hit;
                n_state = S_MWR;
            end
            S_MWR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = emit_byte;
                    n_out_last  = (r_left == t_run_len'(1));
                    n_ptr       = step.nxt;
                    n_src       = r_src + t_ring_addr'(1);
                    n_left      = r_left - t_run_len'(1);
                    if (r_left == t_run_len'(1)) begin
                        n_state = S_IDLE;
                        finish  = 1'b1;
                    end else begin
                        n_state = S_MRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Reset stream state after the last request of a stream
        if (finish && n_last) begin
            n_ptr   = RING_PTR_RESET;
            n_flags = '0;
            n_pair  = 1'b0;
            n_pend  = '0;
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= RING_PTR_RESET;
            r_flags     <= '0;
            r_pair      <= 1'b0;
            r_pend      <= '0;
            r_fill      <= 8'd32;
            r_left      <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_flags     <= n_flags;
            r_pair      <= n_pair;
            r_pend      <= n_pend;
            r_fill      <= n_fill;
            r_left      <= n_left;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
        r_byte     <= n_byte;
        r_src      <= n_src;
        r_hit      <= n_hit;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    `LZSD_ASSERT_NEXT(a_read_then_write, r_state == S_MRD, r_state == S_MWR,
        "ring read not followed by write-back")
    `LZSD_ASSERT_IMP(a_count_bound, 1'b1, r_ptr.cnt <= t_ring_cnt'(RING_DEPTH),
        "ring fill count above ring size")
    `LZSD_ASSERT_IMP(a_copy_left, (r_state == S_MRD) || (r_state == S_MWR),
        (r_left != '0) && (r_left <= t_run_len'(MAX_MATCH)),
        "match copy running with bad remaining length")

endmodule

`default_nettype wire
